// File: design/smfp_pkg.sv
// Shared types, constants and the sigmoid lookup table for the MLP forward-pass block.
// No dependencies. The table is worked out at elaboration by constant functions.
package smfp_pkg;

  localparam int INPUTS      = 3;
  localparam int HIDDEN      = 8;
  localparam int SIG_ENTRIES = 256;
  localparam int SIG_BITS    = $clog2(SIG_ENTRIES);

  localparam int COEF_W = 16;
  localparam int POS_W  = 32;
  localparam int IDX_W  = 6;
  localparam int DENS_W = 16;
  localparam int PROD_W = POS_W + COEF_W;
  localparam int ACC_W  = PROD_W + 3;
  localparam int OSUM_W = 20 + $clog2(HIDDEN + 1);
  localparam int HCNT_W = (HIDDEN > 1) ? $clog2(HIDDEN) : 1;

  localparam logic FUNC_WRITE   = 1'b0;
  localparam logic FUNC_PREDICT = 1'b1;

  localparam logic [63:0] Q32_ONE = 64'd4294967296;
  localparam logic [63:0] Q32_E   = 64'd11674931555;

  typedef logic [SIG_ENTRIES-1:0][DENS_W-1:0] sig_tab_t;

  typedef struct packed {
    logic              wr;
    logic              start;
    logic              issue;
    logic [HCNT_W-1:0] hsel;
    logic              fin_idx;
    logic              fin_load;
  } smfp_cmd_t;

  typedef struct packed {
    logic pipe_empty;
    logic out_free;
  } smfp_stat_t;

  // Restoring long division, elaboration only.
  function automatic logic [63:0] div_u64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] mul_q32(input logic [63:0] a, input logic [63:0] b);
    return (a * (b >> 16) + ((a * (b & 64'hFFFF)) >> 16)) >> 16;
  endfunction

  // Sigmoid at the bin center of entry k.
  function automatic logic [DENS_W-1:0] sig_entry(input int k);
    logic [63:0] n2;
    logic [63:0] m;
    logic [63:0] whole;
    logic [63:0] f;
    logic [63:0] term;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] v;
    logic        neg;
    n2    = 64'(2 * k + 1);
    neg   = (n2 < 64'(SIG_ENTRIES));
    m     = neg ? (64'(SIG_ENTRIES) - n2) : (n2 - 64'(SIG_ENTRIES));
    whole = (m * 64'd8) / SIG_ENTRIES;
    f     = (((m * 64'd8) % SIG_ENTRIES) << 32) / SIG_ENTRIES;
    term  = Q32_ONE;
    e     = Q32_ONE;
    for (int t = 1; t <= 16; t++) begin
      term = div_u64((term * f) >> 32, 64'(t));
      e    = e + term;
    end
    for (int t = 0; t < 16; t++) begin
      if (64'(t) < whole) begin
        e = mul_q32(e, Q32_E);
      end
    end
    den = e + Q32_ONE;
    if (neg) begin
      v = div_u64((Q32_ONE << 17) + den, den << 1);
    end else begin
      v = div_u64((e << 17) + den, den << 1);
    end
    if (v > 64'd65535) begin
      v = 64'd65535;
    end
    return v[DENS_W-1:0];
  endfunction

  function automatic sig_tab_t build_sig_tab();
    sig_tab_t tab;
    for (int k = 0; k < SIG_ENTRIES; k++) begin
      tab[k] = sig_entry(k);
    end
    return tab;
  endfunction

  localparam sig_tab_t SIG_TAB = build_sig_tab();

endpackage

// File: design/smfp_ctrl.sv
// Sequencer for the MLP forward pass: accepts items, steps the hidden-neuron counter,
// waits for the datapath pipeline and hands the result over. Depends on smfp_pkg.
module smfp_ctrl
  import smfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_func,
  output logic       in_stall,
  input  smfp_stat_t stat,
  output smfp_cmd_t  cmd
);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_FIN} state_t;

  state_t            state_r, state_nxt;
  logic [HCNT_W-1:0] h_r, h_nxt;
  logic              accept;

  assign in_stall = !rst_n || (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd.wr       = accept && (in_func == FUNC_WRITE);
    cmd.start    = accept && (in_func == FUNC_PREDICT);
    cmd.issue    = (state_r == ST_RUN);
    cmd.hsel     = h_r;
    cmd.fin_idx  = (state_r == ST_DRAIN) && stat.pipe_empty;
    cmd.fin_load = (state_r == ST_FIN) && stat.out_free;
  end

  always_comb begin
    state_nxt = state_r;
    h_nxt     = h_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.start) begin
          state_nxt = ST_RUN;
          h_nxt     = '0;
        end
      end
      ST_RUN: begin
        if (h_r == HCNT_W'(HIDDEN - 1)) begin
          state_nxt = ST_DRAIN;
        end else begin
          h_nxt = h_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (stat.pipe_empty) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      h_r     <= '0;
    end else begin
      state_r <= state_nxt;
      h_r     <= h_nxt;
    end
  end

endmodule

// File: design/smfp_dp.sv
// Datapath for the MLP forward pass: coefficient store, three-multiply neuron pipeline,
// output accumulator, final sigmoid lookup and result register. Depends on smfp_pkg.
module smfp_dp
  import smfp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  smfp_cmd_t                cmd,
  input  logic [IDX_W-1:0]         in_coef_index,
  input  logic signed [COEF_W-1:0] in_coef_value,
  input  logic signed [POS_W-1:0]  in_pos_x,
  input  logic signed [POS_W-1:0]  in_pos_y,
  input  logic signed [POS_W-1:0]  in_pos_z,
  input  logic                     out_stall,
  output smfp_stat_t               stat,
  output logic                     out_valid,
  output logic [DENS_W-1:0]        out_density
);

  logic [INPUTS-1:0][COEF_W-1:0] wrow_r [HIDDEN];
  logic [COEF_W-1:0]             hbias_r [HIDDEN];
  logic [COEF_W-1:0]             obias_r;

  logic signed [POS_W-1:0]  pos_r [INPUTS];
  logic signed [PROD_W-1:0] prod_r [INPUTS];
  logic signed [COEF_W-1:0] bias_r;
  logic                     v1_r, v2_r;
  logic [SIG_BITS-1:0]      hidx_r, hidx_nxt;
  logic signed [OSUM_W-1:0] osum_r;
  logic [SIG_BITS-1:0]      fidx_r, fidx_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [DENS_W-1:0]        out_density_r;

  logic [INPUTS-1:0][COEF_W-1:0] wsel;
  logic signed [ACC_W-1:0]       hsum;
  logic signed [33:0]            hsat;
  logic signed [19:0]            osat;

  // Coefficient store, cleared at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < HIDDEN; r++) begin
        wrow_r[r]  <= '0;
        hbias_r[r] <= '0;
      end
      obias_r <= '0;
    end else if (cmd.wr) begin
      for (int r = 0; r < HIDDEN; r++) begin
        for (int l = 0; l < INPUTS; l++) begin
          if (int'(in_coef_index) == r * INPUTS + l) begin
            wrow_r[r][l] <= in_coef_value;
          end
        end
        if (int'(in_coef_index) == HIDDEN * INPUTS + r) begin
          hbias_r[r] <= in_coef_value;
        end
      end
      if (int'(in_coef_index) == HIDDEN * (INPUTS + 1)) begin
        obias_r <= in_coef_value;
      end
    end
  end

  assign wsel = wrow_r[cmd.hsel];

  // Neuron sum: add terms, clamp to [-8,8) in Q4.30 and take the table index.
  always_comb begin
    hsum = ACC_W'(prod_r[0]) + ACC_W'(prod_r[1]) + ACC_W'(prod_r[2])
         + (ACC_W'(bias_r) <<< 16);
    if ((&hsum[ACC_W-1:33]) || !(|hsum[ACC_W-1:33])) begin
      hsat = hsum[33:0];
    end else if (hsum[ACC_W-1]) begin
      hsat = {1'b1, 33'd0};
    end else begin
      hsat = {1'b0, {33{1'b1}}};
    end
    hidx_nxt = {~hsat[33], hsat[32 -: SIG_BITS-1]};
  end

  always_comb begin
    if ((&osum_r[OSUM_W-1:19]) || !(|osum_r[OSUM_W-1:19])) begin
      osat = osum_r[19:0];
    end else if (osum_r[OSUM_W-1]) begin
      osat = {1'b1, 19'd0};
    end else begin
      osat = {1'b0, {19{1'b1}}};
    end
    fidx_nxt = {~osat[19], osat[18 -: SIG_BITS-1]};
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      pos_r[0] <= in_pos_x;
      pos_r[1] <= in_pos_y;
      pos_r[2] <= in_pos_z;
    end
    for (int l = 0; l < INPUTS; l++) begin
      prod_r[l] <= pos_r[l] * $signed(wsel[l]);
    end
    bias_r <= $signed(hbias_r[cmd.hsel]);
    hidx_r <= hidx_nxt;
    if (cmd.start) begin
      osum_r <= {{(OSUM_W-COEF_W-2){obias_r[COEF_W-1]}}, obias_r, 2'b00};
    end else if (v2_r) begin
      osum_r <= osum_r + $signed(OSUM_W'(SIG_TAB[hidx_r]));
    end
    if (cmd.fin_idx) begin
      fidx_r <= fidx_nxt;
    end
    if (cmd.fin_load) begin
      out_density_r <= SIG_TAB[fidx_r];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.fin_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= cmd.issue;
      v2_r        <= v1_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign stat.pipe_empty = !v1_r && !v2_r;
  assign stat.out_free   = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_density     = out_density_r;

endmodule

// File: design/sigmoid_mlp_forward_pass_top.sv
// Top level of the sigmoid MLP forward pass: joins the sequencer and the datapath.
// Depends on smfp_pkg, smfp_ctrl and smfp_dp.
//
// Usage:
//   Input channel (in_valid / in_stall): one transfer carries one item. With in_func
//   at write, in_coef_value lands in the coefficient at in_coef_index and no result
//   follows; indexes past the output bias are dropped. With in_func at predict, the
//   position in_pos_x/y/z runs through the network.
//   Result channel (out_valid / out_stall): one transfer of out_density per predict.
//   After a predict transfer the sequencer steps one hidden neuron per cycle (three
//   multipliers in parallel), then drains a two-stage sum/lookup pipeline and does
//   the output lookup, which loads the result register and raises out_valid.
//   Flow: writes are taken back to back; a predict holds in_stall high until its
//   result is loaded into the output register, so the next item waits until then.
//   The next item is taken while a finished result waits in the output register.
//   Stall: a stalled result holds; a further predict completes its work and waits
//   with in_stall high until the output register frees up.
//   Reset (rst_n low, synchronous): clear every coefficient to zero, drop any item in
//   flight and any pending result; in_stall stays high while reset is held.
module sigmoid_mlp_forward_pass_top
  import smfp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_func,
  input  logic [IDX_W-1:0]         in_coef_index,
  input  logic signed [COEF_W-1:0] in_coef_value,
  input  logic signed [POS_W-1:0]  in_pos_x,
  input  logic signed [POS_W-1:0]  in_pos_y,
  input  logic signed [POS_W-1:0]  in_pos_z,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [DENS_W-1:0]        out_density
);

  smfp_cmd_t  cmd;
  smfp_stat_t stat;

  // Sequencing: accept, neuron counter, drain, result handoff.
  smfp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Arithmetic and storage.
  smfp_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_coef_index (in_coef_index),
    .in_coef_value (in_coef_value),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_pos_z      (in_pos_z),
    .out_stall     (out_stall),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_density   (out_density)
  );

`ifndef ASSERT_OFF
  // An input transfer never lands while neuron sums are still in the pipeline.
  a_accept_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> stat.pipe_empty)
    else $error("input transfer with neuron pipeline busy");

  // A predict transfer starts the neuron sequence on the next cycle.
  a_start_issues: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> (cmd.issue && (cmd.hsel == '0)))
    else $error("predict did not start the neuron sequence");

  // A new result only appears after the final lookup was loaded.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.fin_load))
    else $error("result valid without a final lookup");
`endif

endmodule
